@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

  localparam int MODULUS     = 12289;
  localparam int POLY_LENGTH = 512;
  localparam int QUEUE_DEPTH = 8;

  localparam int VALUE_W = 14;
  localparam int BYTE_W  = 8;
  localparam int COMP_W  = 3;
  localparam int PEND_W  = 7;
  localparam int ACC_W   = PEND_W + VALUE_W;
  localparam int NBITS_W = 5;

  localparam logic [NBITS_W-1:0] FULL_BITS = NBITS_W'(VALUE_W);
  localparam logic [NBITS_W-1:0] COMP_BITS = NBITS_W'(COMP_W);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_comp;
    logic               last;
  } entry_t;

endpackage

@@ rtl/poly_coeff_serializer.sv @@
// Packs raw 16-bit coefficients into a byte stream. Each coefficient is reduced
// modulo MODULUS, then appended least significant bit first either as 14 bits
// (format_mode 0) or as a rounded 3-bit compressed value (format_mode 1). Each
// completed byte appears as one result transaction; run_last marks the last
// byte from a coefficient and poly_end the last byte of a POLY_LENGTH
// polynomial, after which leftover bits are dropped. A coefficient can be
// pushed every cycle while full is low into a three-stage reduction pipeline
// feeding an entry queue; the packer writes one byte per cycle to the result
// register while the receiver pops, and writes a two-byte coefficient's second
// byte before taking the next entry. Full mode makes seven bytes per four
// coefficients (never more than two per coefficient), compress mode at most
// one. A coefficient's first byte goes through the pipeline, the queue and the
// result register. Change format_mode only while the block is idle.
module poly_coeff_serializer #(
  parameter int MODULUS     = pcs_pkg::MODULUS,
  parameter int POLY_LENGTH = pcs_pkg::POLY_LENGTH,
  parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] coefficient,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        poly_end
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W = CNT_W + 1;

  logic             accept;
  logic             entry_valid;
  pcs_pkg::entry_t  entry;
  logic [1:0]       inflight;
  pcs_pkg::entry_t  head;
  logic             head_valid;
  logic             head_pop;
  logic [CNT_W-1:0] qcount;
  logic [TOT_W-1:0] occupancy;

  // entries in flight are counted so the pipeline never needs to stall
  assign occupancy = TOT_W'(qcount) + TOT_W'(inflight);
  assign full      = (occupancy >= TOT_W'(QUEUE_DEPTH));
  assign accept    = push && !full;

  pcs_front #(
    .MODULUS     (MODULUS),
    .POLY_LENGTH (POLY_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .coefficient (coefficient),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .entry_valid (entry_valid),
    .entry       (entry),
    .inflight    (inflight)
  );

  pcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (entry_valid),
    .wr_data   (entry),
    .rd_en     (head_pop),
    .rd_data   (head),
    .not_empty (head_valid),
    .count     (qcount)
  );

  pcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .poly_end   (poly_end)
  );

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= TOT_W'(QUEUE_DEPTH))
    else $error("queue occupancy over depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && poly_end) |-> run_last)
    else $error("poly_end without run_last");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> (qcount != '0))
    else $error("entry taken from empty queue");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result after reset");

endmodule

@@ rtl/pcs_front.sv @@
module pcs_front #(
  parameter int MODULUS     = pcs_pkg::MODULUS,
  parameter int POLY_LENGTH = pcs_pkg::POLY_LENGTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [15:0]                   coefficient,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  output logic                          entry_valid,
  output pcs_pkg::entry_t               entry,
  output logic [1:0]                    inflight
);

  localparam int IDX_W = $clog2(POLY_LENGTH);
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + longint'(MODULUS) - 64'd1) / longint'(MODULUS);
  localparam int SUM_W = 18;

  logic [31:0] recip;
  assign recip = 32'(RECIP);

  logic             format_mode;
  logic [IDX_W-1:0] coeff_index;

  logic        s0_valid, s1_valid, s2_valid;
  logic [15:0] s0_x, s1_x;
  logic        s0_comp, s1_comp, s2_comp;
  logic        s0_last, s1_last, s2_last;
  logic [15:0] s1_quot;
  logic [pcs_pkg::VALUE_W-1:0] s2_t;

  logic [47:0] prod;
  logic [15:0] rem;
  logic [SUM_W-1:0] scaled;
  logic [3:0] level;
  logic [pcs_pkg::COMP_W-1:0] comp_val;
  logic last_coeff;

  assign last_coeff = (coeff_index == IDX_W'(POLY_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= 1'b0;
    end else if (cfg_write) begin
      format_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_index <= '0;
      s0_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
    end else begin
      if (accept) begin
        coeff_index <= last_coeff ? '0 : coeff_index + IDX_W'(1);
      end
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  // quotient by reciprocal, exact for 16-bit inputs
  assign prod = {16'b0, s0_x} * {16'b0, recip};
  assign rem  = s1_x - 16'(s1_quot * 16'(MODULUS));

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_x    <= coefficient;
      s0_comp <= format_mode;
      s0_last <= last_coeff;
    end
    s1_x    <= s0_x;
    s1_quot <= prod[47:32];
    s1_comp <= s0_comp;
    s1_last <= s0_last;
    s2_t    <= rem[pcs_pkg::VALUE_W-1:0];
    s2_comp <= s1_comp;
    s2_last <= s1_last;
  end

  // rounded 8*t/q by threshold compares
  assign scaled = {1'b0, s2_t, 3'b000} + SUM_W'(MODULUS / 2);

  always_comb begin
    level = '0;
    for (int k = 1; k <= 8; k++) begin
      if (scaled >= SUM_W'(k * MODULUS)) begin
        level = level + 4'd1;
      end
    end
  end

  assign comp_val = level[pcs_pkg::COMP_W-1:0];

  assign entry_valid   = s2_valid;
  assign entry.value   = s2_comp ? pcs_pkg::VALUE_W'(comp_val) : s2_t;
  assign entry.is_comp = s2_comp;
  assign entry.last    = s2_last;
  assign inflight      = 2'(s0_valid) + 2'(s1_valid) + 2'(s2_valid);

endmodule

@@ rtl/pcs_queue.sv @@
module pcs_queue #(
  parameter int DEPTH = pcs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  pcs_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  output pcs_pkg::entry_t            rd_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcs_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] head, tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (rd_en) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[tail] <= wr_data;
    end
  end

  assign rd_data   = slots[head];
  assign not_empty = (count != '0);

endmodule

@@ rtl/pcs_back.sv @@
module pcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  pcs_pkg::entry_t     head,
  output logic                head_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                poly_end
);

  logic [pcs_pkg::PEND_W-1:0]  pend_bits;
  logic [2:0]                  pend_cnt;
  logic                        out_valid;
  logic                        second_valid;
  logic [7:0]                  second_byte;
  logic                        second_end;

  logic [pcs_pkg::ACC_W-1:0]   acc;
  logic [pcs_pkg::NBITS_W-1:0] nbits;
  logic [1:0]                  nbytes;
  logic [2:0]                  rem_cnt;
  logic [pcs_pkg::PEND_W-1:0]  rem_bits;
  logic [pcs_pkg::PEND_W-1:0]  rem_mask;
  logic                        slot_free;

  assign acc = pcs_pkg::ACC_W'(pend_bits)
             | (pcs_pkg::ACC_W'(head.value) << pend_cnt);
  assign nbits = pcs_pkg::NBITS_W'(pend_cnt)
               + (head.is_comp ? pcs_pkg::COMP_BITS : pcs_pkg::FULL_BITS);

  always_comb begin
    if (nbits >= pcs_pkg::NBITS_W'(16)) begin
      nbytes   = 2'd2;
      rem_bits = pcs_pkg::PEND_W'(acc[pcs_pkg::ACC_W-1:16]);
    end else if (nbits >= pcs_pkg::NBITS_W'(8)) begin
      nbytes   = 2'd1;
      rem_bits = acc[8 +: pcs_pkg::PEND_W];
    end else begin
      nbytes   = 2'd0;
      rem_bits = acc[pcs_pkg::PEND_W-1:0];
    end
  end

  assign rem_cnt   = nbits[2:0];
  assign rem_mask  = pcs_pkg::PEND_W'((8'd1 << rem_cnt) - 8'd1);
  assign slot_free = !out_valid || pop;
  assign head_pop  = head_valid && !second_valid && (slot_free || nbytes == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits    <= '0;
      pend_cnt     <= '0;
      out_valid    <= 1'b0;
      second_valid <= 1'b0;
    end else begin
      if (head_pop) begin
        if (head.last) begin
          pend_bits <= '0;
          pend_cnt  <= '0;
        end else begin
          pend_bits <= rem_bits & rem_mask;
          pend_cnt  <= rem_cnt;
        end
      end
      if (slot_free) begin
        out_valid <= second_valid || (head_pop && nbytes != 2'd0);
      end
      if (second_valid && slot_free) begin
        second_valid <= 1'b0;
      end else if (head_pop && nbytes == 2'd2) begin
        second_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (second_valid) begin
        out_byte <= second_byte;
        run_last <= 1'b1;
        poly_end <= second_end;
      end else begin
        out_byte <= acc[7:0];
        run_last <= (nbytes == 2'd1);
        poly_end <= head.last && (nbytes == 2'd1);
      end
    end
    if (head_pop) begin
      second_byte <= acc[15:8];
      second_end  <= head.last;
    end
  end

  assign empty = !out_valid;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       poly_end;
  } packed_byte_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [15:0] coefficient;
  logic        cfg_write;
  logic        cfg_data;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        poly_end;

  // packer model state
  logic        fmt_compress;
  logic [6:0]  carry_bits;
  int unsigned carry_count;
  int unsigned coeff_pos;

  packed_byte_t packed_bytes_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;
  int error_count;

  poly_coeff_serializer u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .coefficient(coefficient),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .poly_end   (poly_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL poly_coeff_serializer");
    $finish;
  end

  // expected bytes for one accepted coefficient
  task automatic pack_coefficient(input logic [15:0] raw);
    int unsigned  residue;
    int unsigned  acc;
    int unsigned  nbits;
    int           n;
    logic         last_coeff;
    packed_byte_t made[2];
    residue    = raw % pcs_pkg::MODULUS;
    last_coeff = (coeff_pos + 1 >= pcs_pkg::POLY_LENGTH);
    if (fmt_compress) begin
      acc   = carry_bits
            | ((((residue << 3) + pcs_pkg::MODULUS / 2) / pcs_pkg::MODULUS) & 32'h7)
              << carry_count;
      nbits = carry_count + pcs_pkg::COMP_W;
    end else begin
      acc   = carry_bits | ((residue & 32'h3fff) << carry_count);
      nbits = carry_count + pcs_pkg::VALUE_W;
    end
    n = 0;
    while (nbits >= 8 && n < 2) begin
      made[n].data     = acc[7:0];
      made[n].run_last = 1'b0;
      made[n].poly_end = 1'b0;
      acc   = acc >> 8;
      nbits = nbits - 8;
      n++;
    end
    if (n > 0) begin
      made[n-1].run_last = 1'b1;
      made[n-1].poly_end = last_coeff;
    end
    for (int i = 0; i < n; i++) packed_bytes_q.push_back(made[i]);
    if (last_coeff) begin
      carry_bits  = '0;
      carry_count = 0;
      coeff_pos   = 0;
    end else begin
      carry_count = nbits & 7;
      carry_bits  = 7'(acc & ((1 << carry_count) - 1));
      coeff_pos++;
    end
  endtask

  task automatic send_coeff(input logic [15:0] value);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    push        = 1'b1;
    coefficient = value;
    @(posedge clk);
    while (full) @(posedge clk);
    pack_coefficient(value);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_drained();
    while (packed_bytes_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(input logic compress);
    cfg_write = 1'b1;
    cfg_data  = compress;
    @(negedge clk);
    cfg_write    = 1'b0;
    cfg_data     = 1'b0;
    fmt_compress = compress;
  endtask

  function automatic logic [15:0] pick_coeff();
    int unsigned k;
    int unsigned j;
    k = $urandom_range(5, 1);
    case ($urandom_range(9))
      6: return 16'(k * pcs_pkg::MODULUS - 2 + $urandom_range(4));
      7: begin
        j = $urandom_range(7);
        return 16'(((2 * j + 1) * pcs_pkg::MODULUS) / 16 - 1 + $urandom_range(2)
                   + (k - 1) * pcs_pkg::MODULUS);
      end
      8: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic test_full_extremes();
    logic [15:0] vals[8];
    vals = '{16'h0000, 16'hffff, 16'(pcs_pkg::MODULUS - 1), 16'(pcs_pkg::MODULUS),
             16'(pcs_pkg::MODULUS + 1), 16'h3fff, 16'(2 * pcs_pkg::MODULUS - 1),
             16'h8000};
    foreach (vals[i]) send_coeff(vals[i]);
    wait_drained();
  endtask

  task automatic test_compress_rounding();
    logic [15:0] vals[8];
    vals = '{16'd0, 16'd768, 16'd769, 16'd6144, 16'd6145, 16'd11520, 16'd11521,
             16'(pcs_pkg::MODULUS - 1)};
    set_format(1'b1);
    foreach (vals[i]) send_coeff(vals[i]);
    wait_drained();
  endtask

  // width change with bits still waiting in the packer
  task automatic test_mode_switch();
    repeat (3) send_coeff(pick_coeff());
    wait_drained();
    set_format(1'b0);
    repeat (3) send_coeff(pick_coeff());
    wait_drained();
    set_format(1'b1);
    repeat (2) send_coeff(pick_coeff());
    wait_drained();
  endtask

  task automatic test_input_stall();
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    set_format(1'b0);
    rx_hold_cycles = 300;
    repeat (60) send_coeff(pick_coeff());
    wait_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int sent;
    int chunk;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      chunk = $urandom_range(220, 10);
      if (chunk > count - sent) chunk = count - sent;
      repeat (chunk) send_coeff(pick_coeff());
      sent += chunk;
      wait_drained();
      set_format(1'($urandom_range(1)));
    end
  endtask

  // receiver side
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        pop = 1'b0;
        rx_hold_cycles--;
      end else begin
        pop = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    packed_byte_t want;
    if (!rst && pop && !empty) begin
      if (packed_bytes_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction byte=%02h run_last=%b poly_end=%b",
                   $realtime, out_byte, run_last, poly_end);
      end else begin
        want = packed_bytes_q.pop_front();
        if (out_byte !== want.data || run_last !== want.run_last ||
            poly_end !== want.poly_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch exp %02h/%b/%b got %02h/%b/%b",
                     $realtime, want.data, want.run_last, want.poly_end,
                     out_byte, run_last, poly_end);
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    coefficient    = '0;
    cfg_write      = 1'b0;
    cfg_data       = 1'b0;
    fmt_compress   = 1'b0;
    carry_bits     = '0;
    carry_count    = 0;
    coeff_pos      = 0;
    tx_idle_pct    = 18;
    rx_idle_pct    = 59;
    rx_hold_cycles = 0;
    error_count    = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_full_extremes();
    test_compress_rounding();
    test_mode_switch();
    test_random_traffic(18, 59, 570);
    test_random_traffic(59, 18, 570);
    test_input_stall();
    test_random_traffic(0, 0, 570);

    wait_drained();
    if (error_count == 0 && packed_bytes_q.size() == 0) begin
      $display("PASS poly_coeff_serializer");
    end else begin
      $display("FAIL poly_coeff_serializer");
    end
    $finish;
  end

endmodule
